[rtl/dgpi_pkg.sv]
package dgpi_pkg;

	// channel organization
	localparam int unsigned NumCh     = 6;
	localparam int unsigned GroupSize = 3;
	localparam int unsigned NumGroups = NumCh / GroupSize;

	// datapath widths
	localparam int unsigned DataW     = 16;                  // readings, targets, pressures
	localparam int unsigned ErrW      = DataW + 1;           // reading - target
	localparam int unsigned DiffW     = ErrW + 2;            // S - 2*e
	localparam int unsigned ProdW     = DiffW + DataW + 1;   // diff * gain, signed
	localparam int unsigned ProdShift = 19;                  // Q17.19 -> Q16.0
	localparam int unsigned UpdW      = DataW + 1;           // store + increment
	localparam int unsigned SumW      = UpdW + 2;            // sum of three updates
	localparam int unsigned MagW      = SumW - 1;            // |sum| stays below 2^18
	localparam int unsigned Div3W     = 18;
	localparam int unsigned Div3Shift = 19;
	localparam int unsigned QuotW     = MagW + Div3W - Div3Shift;
	localparam int unsigned MeanW     = QuotW;
	localparam int unsigned ResW      = UpdW + 1;            // update - mean

	// ceil(2^19 / 3); exact floor(x/3) for x < 2^18
	localparam logic [Div3W-1:0] Div3Mult = 18'd174763;

	// configuration port
	localparam int unsigned CfgIdxW = 3;

	typedef logic        [DataW-1:0] word_t;
	typedef logic signed [DataW-1:0] press_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TARGET_0  = 3'd0,
		REG_TARGET_1  = 3'd1,
		REG_TARGET_2  = 3'd2,
		REG_TARGET_3  = 3'd3,
		REG_TARGET_4  = 3'd4,
		REG_TARGET_5  = 3'd5,
		REG_STEP_GAIN = 3'd6
	} cfg_reg_t;

	// reset values, channel 0 in the low slot
	localparam word_t [NumCh-1:0] TargetReset = {
		16'd59258, 16'd53813, 16'd52211, 16'd34914, 16'd34274, 16'd38758
	};
	localparam word_t StepGainReset = 16'd16384;

	// stage load strobes from the top-level pipeline control
	typedef struct packed {
		logic load_s2;
		logic load_out;
	} dgpi_ctrl_t;

	// clamp to the signed 16-bit range
	function automatic press_t sat16(input logic signed [ResW-1:0] v);
		press_t r;
		if (!v[ResW-1] && (|v[ResW-2:DataW-1])) begin
			r = {1'b0, {(DataW-1){1'b1}}};
		end else if (v[ResW-1] && !(&v[ResW-2:DataW-1])) begin
			r = {1'b1, {(DataW-1){1'b0}}};
		end else begin
			r = v[DataW-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/dgpi_sample_if.sv]
interface dgpi_sample_if;
	import dgpi_pkg::*;

	logic  valid;
	logic  ready;
	word_t reading_0;
	word_t reading_1;
	word_t reading_2;
	word_t reading_3;
	word_t reading_4;
	word_t reading_5;

	modport source (
		output valid, reading_0, reading_1, reading_2, reading_3, reading_4, reading_5,
		input  ready
	);
	modport sink (
		input  valid, reading_0, reading_1, reading_2, reading_3, reading_4, reading_5,
		output ready
	);
endinterface

[rtl/dgpi_result_if.sv]
interface dgpi_result_if;
	import dgpi_pkg::*;

	logic   valid;
	logic   ready;
	press_t pressure_0;
	press_t pressure_1;
	press_t pressure_2;
	press_t pressure_3;
	press_t pressure_4;
	press_t pressure_5;

	modport source (
		output valid, pressure_0, pressure_1, pressure_2, pressure_3, pressure_4, pressure_5,
		input  ready
	);
	modport sink (
		input  valid, pressure_0, pressure_1, pressure_2, pressure_3, pressure_4, pressure_5,
		output ready
	);
endinterface

[rtl/dgpi_group.sv]
module dgpi_group (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  dgpi_pkg::dgpi_ctrl_t                       ctrl,
	input  dgpi_pkg::word_t  [dgpi_pkg::GroupSize-1:0] reading,
	input  dgpi_pkg::word_t  [dgpi_pkg::GroupSize-1:0] target,
	input  dgpi_pkg::word_t                            step_gain,
	output dgpi_pkg::press_t [dgpi_pkg::GroupSize-1:0] pressure
);
	import dgpi_pkg::*;

	logic signed [ErrW-1:0]  err  [GroupSize];
	logic signed [DiffW-1:0] sum_err;
	logic signed [DiffW-1:0] diff [GroupSize];
	logic signed [ProdW-1:0] prod [GroupSize];
	logic signed [ProdW-1:0] gain_ext;
	press_t [GroupSize-1:0]  inc_c;
	press_t [GroupSize-1:0]  inc_s2;

	logic signed [UpdW-1:0]  upd  [GroupSize];
	logic signed [SumW-1:0]  total;
	logic                    total_neg;
	logic        [SumW-1:0]  mag_full;
	logic        [MagW-1:0]  mag;
	logic [MagW+Div3W-1:0]   quot_prod;
	logic        [QuotW-1:0] quot;
	logic signed [MeanW-1:0] mean;
	logic signed [ResW-1:0]  res  [GroupSize];
	press_t [GroupSize-1:0]  store_c;
	press_t [GroupSize-1:0]  store_q;

	// errors, group sum and gain product per channel
	always_comb begin
		gain_ext = signed'(ProdW'({1'b0, step_gain}));
		for (int j = 0; j < GroupSize; j++) begin
			err[j] = signed'({1'b0, reading[j]}) - signed'({1'b0, target[j]});
		end
		sum_err = '0;
		for (int j = 0; j < GroupSize; j++) begin
			sum_err = sum_err + DiffW'(err[j]);
		end
		for (int j = 0; j < GroupSize; j++) begin
			diff[j]  = sum_err - (DiffW'(err[j]) <<< 1);
			prod[j]  = ProdW'(diff[j]) * gain_ext;
			// floor shift; the result always fits 16 bits
			inc_c[j] = prod[j][ProdShift+DataW-1:ProdShift];
		end
	end

	// increment register
	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			inc_s2 <= inc_c;
		end
	end

	// store update, group mean removal, saturation
	always_comb begin
		for (int j = 0; j < GroupSize; j++) begin
			upd[j] = UpdW'(signed'(store_q[j])) + UpdW'(signed'(inc_s2[j]));
		end
		total = '0;
		for (int j = 0; j < GroupSize; j++) begin
			total = total + SumW'(upd[j]);
		end
		total_neg = total[SumW-1];
		mag_full  = total_neg ? unsigned'(-total) : unsigned'(total);
		mag       = mag_full[MagW-1:0];
		// divide by three through the reciprocal, truncating toward zero
		quot_prod = (MagW+Div3W)'(mag) * (MagW+Div3W)'(Div3Mult);
		quot      = quot_prod[Div3Shift +: QuotW];
		mean      = total_neg ? -signed'(quot) : signed'(quot);
		for (int j = 0; j < GroupSize; j++) begin
			res[j]     = ResW'(upd[j]) - ResW'(mean);
			store_c[j] = sat16(res[j]);
		end
	end

	// pressure store, also the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (ctrl.load_out) begin
			store_q <= store_c;
		end
	end

	assign pressure = store_q;

endmodule

[rtl/dual_group_pressure_integrator_top.sv]
// A sample word goes through the input, increment and pressure store registers;
// result word follows. Throughput: one sample word per cycle while results are
// taken, set by each group's store update (add, mean by reciprocal, saturate).
// Reset: pressures clear to zero, targets and step gain take their defaults,
// and the pipeline empties; no clearing pass is needed.
module dual_group_pressure_integrator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dgpi_pkg::CfgIdxW-1:0]  cfg_index,
	input  dgpi_pkg::word_t               cfg_wdata,
	dgpi_sample_if.sink                   sample,
	dgpi_result_if.source                 result
);
	import dgpi_pkg::*;

	word_t [NumCh-1:0]   target_q;
	word_t               step_gain_q;
	word_t [NumCh-1:0]   reading_s1;
	logic                valid_s1;
	logic                valid_s2;
	logic                out_valid_q;
	logic                ready_s1;
	logic                ready_s2;
	logic                ready_out;
	dgpi_ctrl_t          ctrl;
	press_t [NumCh-1:0]  pressure_all;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= TargetReset;
			step_gain_q <= StepGainReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TARGET_0:  target_q[0]  <= cfg_wdata;
				REG_TARGET_1:  target_q[1]  <= cfg_wdata;
				REG_TARGET_2:  target_q[2]  <= cfg_wdata;
				REG_TARGET_3:  target_q[3]  <= cfg_wdata;
				REG_TARGET_4:  target_q[4]  <= cfg_wdata;
				REG_TARGET_5:  target_q[5]  <= cfg_wdata;
				REG_STEP_GAIN: step_gain_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// per-stage ready: a stage moves when it is empty or its word moves on
	assign ready_out     = !out_valid_q || result.ready;
	assign ready_s2      = !valid_s2 || ready_out;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign sample.ready  = ready_s1;
	assign ctrl.load_s2  = valid_s1 && ready_s2;
	assign ctrl.load_out = valid_s2 && ready_out;

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= sample.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// input word register
	always_ff @(posedge clk) begin
		if (sample.valid && ready_s1) begin
			reading_s1 <= {sample.reading_5, sample.reading_4, sample.reading_3,
				sample.reading_2, sample.reading_1, sample.reading_0};
		end
	end

	// one datapath per group of three channels
	for (genvar g = 0; g < NumGroups; g++) begin : g_group
		dgpi_group u_group (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.reading   (reading_s1[g*GroupSize +: GroupSize]),
			.target    (target_q[g*GroupSize +: GroupSize]),
			.step_gain (step_gain_q),
			.pressure  (pressure_all[g*GroupSize +: GroupSize])
		);
	end

	// result word
	assign result.valid      = out_valid_q;
	assign result.pressure_0 = pressure_all[0];
	assign result.pressure_1 = pressure_all[1];
	assign result.pressure_2 = pressure_all[2];
	assign result.pressure_3 = pressure_all[3];
	assign result.pressure_4 = pressure_all[4];
	assign result.pressure_5 = pressure_all[5];

	// a held result word must not see the store move underneath it
	a_store_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> $stable(pressure_all))
		else $error("pressure store changed while result word stalled");

	// an empty front stage always takes a word
	a_front_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> sample.ready)
		else $error("front stage empty but not ready");

	// a word in stage two that may move reaches the output next cycle
	a_s2_advances: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ready_out |=> out_valid_q)
		else $error("stage two word lost");

	// the store only moves when a word enters the output register
	a_store_only_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.load_out |=> $stable(pressure_all))
		else $error("pressure store changed without a load");

endmodule
